// File: src/acm_pkg.sv
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and codes of the multi-pattern letter matcher: item and
// result words, action codes, controller micro-op codes and status word.
// ----------------------------------------------------------------------------
`default_nettype none

package acm_pkg;

    localparam int SYM_W = 8;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] letter;
        logic       last;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [7:0]  hits_here;
        logic [15:0] hit_total;
        logic [10:0] nodes_used;
    } t_result;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_BUILD  = 2'd1;
    localparam logic [1:0] ACT_SCAN   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP    = 5'd0;
    localparam t_op OP_LOAD   = 5'd1;
    localparam t_op OP_I_RD   = 5'd2;
    localparam t_op OP_I_UPD  = 5'd3;
    localparam t_op OP_S_RD   = 5'd4;
    localparam t_op OP_S_CHK  = 5'd5;
    localparam t_op OP_S_HRD  = 5'd6;
    localparam t_op OP_S_ACC  = 5'd7;
    localparam t_op OP_B_INIT = 5'd8;
    localparam t_op OP_B_ROOT = 5'd9;
    localparam t_op OP_B_POP  = 5'd10;
    localparam t_op OP_B_PGET = 5'd11;
    localparam t_op OP_B_CRD  = 5'd12;
    localparam t_op OP_B_CSET = 5'd13;
    localparam t_op OP_B_NEXT = 5'd14;
    localparam t_op OP_B_QRD  = 5'd15;
    localparam t_op OP_B_QCHK = 5'd16;
    localparam t_op OP_B_FRD  = 5'd17;
    localparam t_op OP_B_HWR  = 5'd18;
    localparam t_op OP_C_INIT = 5'd19;
    localparam t_op OP_SWEEP  = 5'd20;
    localparam t_op OP_REPORT = 5'd21;

    typedef struct packed {
        logic [1:0] action;
        logic       last;
        logic       child_nz;
        logic       q_zero;
        logic       p_zero;
        logic       s_last;
        logic       more;
        logic       sweep_last;
    } t_stat;

endpackage

`default_nettype wire

// File: src/aho_corasick_matcher.sv
// ----------------------------------------------------------------------------
// aho_corasick_matcher
// Multi-pattern matcher over lower-case letters: insert, build, scan, clear.
// ----------------------------------------------------------------------------
// Issue a word with start while busy is low; its result appears on o_result
// for exactly one cycle with o_done high and must be taken then. One word is
// handled at a time. Insert steps through a child read, an update and the
// report; scan through a child read and check, repeated per failure link
// followed, then a hit read, accumulation and the report; build walks the
// node queue, each letter and failure link a read of the child memory.
// After reset and on clear the child table is swept one entry a cycle, all
// MAX_NODES*ALPHABET entries (26624 by default), with busy high throughout.
`default_nettype none

module aho_corasick_matcher
    import acm_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int ALPHABET   = 26,
    parameter int TOTAL_BITS = 16
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     start,
    input  t_item   i_item,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    t_op   op;
    t_stat stat;

    acm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_op    (op),
        .busy    (busy)
    );

    acm_datapath #(
        .MAX_NODES  (MAX_NODES),
        .ALPHABET   (ALPHABET),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a word in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// File: src/acm_ctrl.sv
// ----------------------------------------------------------------------------
// acm_ctrl
// Sequencer of the matcher: steps each action through its micro-ops and
// runs the table clearing pass after reset and on clear.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_ctrl
    import acm_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   start,
    input  t_stat i_stat,
    output t_op   o_op,
    output logic  busy
);

    localparam logic [4:0] ST_SWEEP_RST = 5'd0;
    localparam logic [4:0] ST_IDLE      = 5'd1;
    localparam logic [4:0] ST_DISP      = 5'd2;
    localparam logic [4:0] ST_I_RD      = 5'd3;
    localparam logic [4:0] ST_I_UPD     = 5'd4;
    localparam logic [4:0] ST_S_RD      = 5'd5;
    localparam logic [4:0] ST_S_CHK     = 5'd6;
    localparam logic [4:0] ST_S_HRD     = 5'd7;
    localparam logic [4:0] ST_S_ACC     = 5'd8;
    localparam logic [4:0] ST_B_INIT    = 5'd9;
    localparam logic [4:0] ST_B_ROOT    = 5'd10;
    localparam logic [4:0] ST_B_POP     = 5'd11;
    localparam logic [4:0] ST_B_PGET    = 5'd12;
    localparam logic [4:0] ST_B_CRD     = 5'd13;
    localparam logic [4:0] ST_B_CCHK    = 5'd14;
    localparam logic [4:0] ST_B_QRD     = 5'd15;
    localparam logic [4:0] ST_B_QCHK    = 5'd16;
    localparam logic [4:0] ST_B_FRD     = 5'd17;
    localparam logic [4:0] ST_B_HWR     = 5'd18;
    localparam logic [4:0] ST_C_INIT    = 5'd19;
    localparam logic [4:0] ST_SWEEP_CLR = 5'd20;
    localparam logic [4:0] ST_REPORT    = 5'd21;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP_RST;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_op    = OP_NOP;
        unique case (r_state)
            ST_SWEEP_RST: begin
                o_op = OP_SWEEP;
                if (i_stat.sweep_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    o_op    = OP_LOAD;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_stat.action)
                    ACT_INSERT: n_state = ST_I_RD;
                    ACT_BUILD:  n_state = ST_B_INIT;
                    ACT_SCAN:   n_state = ST_S_RD;
                    ACT_CLEAR:  n_state = ST_C_INIT;
                endcase
            end
            ST_I_RD: begin
                o_op    = OP_I_RD;
                n_state = ST_I_UPD;
            end
            ST_I_UPD: begin
                o_op    = OP_I_UPD;
                n_state = ST_REPORT;
            end
            ST_S_RD: begin
                o_op    = OP_S_RD;
                n_state = ST_S_CHK;
            end
            ST_S_CHK: begin
                o_op    = OP_S_CHK;
                n_state = (i_stat.child_nz || i_stat.q_zero) ? ST_S_HRD : ST_S_RD;
            end
            ST_S_HRD: begin
                o_op    = OP_S_HRD;
                n_state = ST_S_ACC;
            end
            ST_S_ACC: begin
                o_op    = OP_S_ACC;
                n_state = ST_REPORT;
            end
            ST_B_INIT: begin
                o_op    = OP_B_INIT;
                n_state = ST_B_ROOT;
            end
            ST_B_ROOT: begin
                o_op    = OP_B_ROOT;
                n_state = ST_B_POP;
            end
            ST_B_POP: begin
                if (i_stat.more) begin
                    o_op    = OP_B_POP;
                    n_state = ST_B_PGET;
                end else begin
                    n_state = ST_REPORT;
                end
            end
            ST_B_PGET: begin
                o_op    = OP_B_PGET;
                n_state = ST_B_CRD;
            end
            ST_B_CRD: begin
                o_op    = OP_B_CRD;
                n_state = ST_B_CCHK;
            end
            ST_B_CCHK: begin
                if (i_stat.child_nz) begin
                    o_op    = OP_B_CSET;
                    n_state = i_stat.p_zero ? ST_B_FRD : ST_B_QRD;
                end else begin
                    o_op    = OP_B_NEXT;
                    n_state = i_stat.s_last ? ST_B_POP : ST_B_CRD;
                end
            end
            ST_B_QRD: begin
                o_op    = OP_B_QRD;
                n_state = ST_B_QCHK;
            end
            ST_B_QCHK: begin
                o_op    = OP_B_QCHK;
                n_state = (i_stat.child_nz || i_stat.q_zero) ? ST_B_FRD : ST_B_QRD;
            end
            ST_B_FRD: begin
                o_op    = OP_B_FRD;
                n_state = ST_B_HWR;
            end
            ST_B_HWR: begin
                o_op    = OP_B_HWR;
                n_state = i_stat.s_last ? ST_B_POP : ST_B_CRD;
            end
            ST_C_INIT: begin
                o_op    = OP_C_INIT;
                n_state = ST_SWEEP_CLR;
            end
            ST_SWEEP_CLR: begin
                o_op = OP_SWEEP;
                if (i_stat.sweep_last) n_state = ST_REPORT;
            end
            ST_REPORT: begin
                o_op    = OP_REPORT;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// File: src/acm_datapath.sv
// ----------------------------------------------------------------------------
// acm_datapath
// Node memories, walk queue, position and count registers of the matcher;
// executes one micro-op per cycle and reports status to the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module acm_datapath
    import acm_pkg::*;
#(
    parameter int MAX_NODES  = 1024,
    parameter int ALPHABET   = 26,
    parameter int TOTAL_BITS = 16
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_op     i_op,
    input  t_item   i_item,
    output t_stat   o_stat,
    output logic    o_done,
    output t_result o_result
);

    localparam int NW   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int TW   = $clog2(MAX_NODES + 1);
    localparam int SW   = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int CD   = MAX_NODES * ALPHABET;
    localparam int CAW  = $clog2(CD);
    localparam int SUMW = ((TOTAL_BITS > 8) ? TOTAL_BITS : 8) + 1;

    logic [NW-1:0] child_mem [CD];
    logic [NW-1:0] fail_mem  [MAX_NODES];
    logic [7:0]    hits_mem  [MAX_NODES];
    logic          end_mem   [MAX_NODES];
    logic [NW-1:0] queue_mem [MAX_NODES];

    logic [NW-1:0] r_child_rd;
    logic [NW-1:0] r_fail_rd;
    logic [7:0]    r_hits_rd;
    logic          r_end_rd;
    logic [NW-1:0] r_queue_rd;

    t_item           r_item;
    logic            r_sym_ok;
    logic [TW-1:0]   r_node_total;
    logic [NW-1:0]   r_ins_pos;
    logic            r_drop;
    logic [NW-1:0]   r_scan_pos;
    logic [TOTAL_BITS-1:0] r_run;
    logic [TW-1:0]   r_head;
    logic [TW-1:0]   r_tail;
    logic [NW-1:0]   r_p;
    logic [NW-1:0]   r_q;
    logic [NW-1:0]   r_c;
    logic [NW-1:0]   r_f;
    logic [SW-1:0]   r_s;
    logic [CAW-1:0]  r_sweep;
    logic            r_stat;
    logic [7:0]      r_hit;
    logic            r_done;
    t_result         r_result;

    logic [NW-1:0]    node_sel;
    logic [SYM_W-1:0] sym_sel;
    logic [CAW-1:0]   c_rd_addr;
    logic [CAW-1:0]   ins_addr;
    logic             sweep_node;
    logic [NW-1:0]    sweep_idx;

    logic          c_we;
    logic [CAW-1:0] c_wa;
    logic [NW-1:0] c_wd;
    logic          f_we;
    logic [NW-1:0] f_wa;
    logic [NW-1:0] f_wd;
    logic          h_we;
    logic [NW-1:0] h_wa;
    logic [7:0]    h_wd;
    logic          e_we;
    logic [NW-1:0] e_wa;
    logic          q_we;
    logic [NW-1:0] q_wa;
    logic [NW-1:0] q_wd;
    logic [NW-1:0] h_ra;
    logic [NW-1:0] e_ra;

    logic          ins_drop;
    logic [NW-1:0] ins_pos;
    logic          ins_alloc;
    logic [8:0]    hsum;
    logic [7:0]    hsat;
    logic [SUMW-1:0] rsum;
    logic [TOTAL_BITS-1:0] rsat;

    assign sweep_node = (r_sweep < CAW'(MAX_NODES));
    assign sweep_idx  = r_sweep[NW-1:0];

    always_comb begin
        node_sel = r_q;
        sym_sel  = SYM_W'(r_s);
        unique case (i_op)
            OP_I_RD: begin
                node_sel = r_ins_pos;
                sym_sel  = SYM_W'(r_item.letter);
            end
            OP_S_RD: sym_sel = SYM_W'(r_item.letter);
            OP_B_CRD: node_sel = r_p;
            default: ;
        endcase
    end

    assign c_rd_addr = CAW'(node_sel * ALPHABET + sym_sel);
    assign ins_addr  = CAW'(r_ins_pos * ALPHABET + r_item.letter);
    assign h_ra      = (i_op == OP_B_FRD) ? r_f : r_q;
    assign e_ra      = (i_op == OP_B_FRD) ? r_c : '0;

    always_comb begin
        ins_drop  = r_drop;
        ins_pos   = r_ins_pos;
        ins_alloc = 1'b0;
        if (!r_drop) begin
            if (r_sym_ok && r_child_rd != '0) begin
                ins_pos = r_child_rd;
            end else if (r_sym_ok && r_node_total < TW'(MAX_NODES)) begin
                ins_pos   = NW'(r_node_total);
                ins_alloc = 1'b1;
            end else begin
                ins_drop = 1'b1;
            end
        end
    end

    assign hsum = 9'(r_end_rd) + 9'(r_hits_rd);
    assign hsat = (hsum > 9'd255) ? 8'hFF : hsum[7:0];
    assign rsum = SUMW'(r_run) + SUMW'(r_hits_rd);
    assign rsat = (rsum > SUMW'({TOTAL_BITS{1'b1}})) ? {TOTAL_BITS{1'b1}}
                                                     : rsum[TOTAL_BITS-1:0];

    always_comb begin
        c_we = 1'b0;
        c_wa = ins_addr;
        c_wd = ins_pos;
        f_we = 1'b0;
        f_wa = r_c;
        f_wd = r_f;
        h_we = 1'b0;
        h_wa = r_c;
        h_wd = hsat;
        e_we = 1'b0;
        e_wa = ins_pos;
        q_we = 1'b0;
        q_wa = r_tail[NW-1:0];
        q_wd = r_c;
        unique case (i_op)
            OP_I_UPD: begin
                c_we = ins_alloc;
                e_we = r_item.last && !ins_drop;
            end
            OP_B_INIT: begin
                f_we = 1'b1;
                f_wa = '0;
                f_wd = '0;
                q_we = 1'b1;
                q_wa = '0;
                q_wd = '0;
            end
            OP_B_ROOT: begin
                h_we = 1'b1;
                h_wa = '0;
                h_wd = 8'(r_end_rd);
            end
            OP_B_FRD: f_we = 1'b1;
            OP_B_HWR: begin
                h_we = 1'b1;
                q_we = (r_tail < TW'(MAX_NODES));
            end
            OP_SWEEP: begin
                c_we = 1'b1;
                c_wa = r_sweep;
                c_wd = '0;
                f_we = sweep_node;
                f_wa = sweep_idx;
                f_wd = '0;
                h_we = sweep_node;
                h_wa = sweep_idx;
                h_wd = '0;
                e_we = sweep_node;
                e_wa = sweep_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) child_mem[c_wa] <= c_wd;
        r_child_rd <= child_mem[c_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) fail_mem[f_wa] <= f_wd;
        r_fail_rd <= fail_mem[node_sel];
    end

    always_ff @(posedge i_clk) begin
        if (h_we) hits_mem[h_wa] <= h_wd;
        r_hits_rd <= hits_mem[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (e_we) end_mem[e_wa] <= (i_op != OP_SWEEP);
        r_end_rd <= end_mem[e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) queue_mem[q_wa] <= q_wd;
        r_queue_rd <= queue_mem[r_head[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_total <= TW'(1);
            r_ins_pos    <= '0;
            r_drop       <= 1'b0;
            r_scan_pos   <= '0;
            r_run        <= '0;
            r_sweep      <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_done <= (i_op == OP_REPORT);
            unique case (i_op)
                OP_LOAD: begin
                    r_item   <= i_item;
                    r_sym_ok <= (int'(i_item.letter) < ALPHABET);
                    r_q      <= r_scan_pos;
                    r_stat   <= 1'b0;
                    r_hit    <= '0;
                end
                OP_I_UPD: begin
                    if (ins_alloc) r_node_total <= r_node_total + TW'(1);
                    r_ins_pos <= r_item.last ? '0 : ins_pos;
                    r_stat    <= ins_drop;
                    r_drop    <= r_item.last ? 1'b0 : ins_drop;
                end
                OP_S_CHK: begin
                    if (r_sym_ok && r_child_rd != '0) begin
                        r_q <= r_child_rd;
                    end else if (r_q != '0) begin
                        r_q <= r_fail_rd;
                    end
                end
                OP_S_ACC: begin
                    r_hit      <= r_hits_rd;
                    r_run      <= rsat;
                    r_scan_pos <= r_q;
                end
                OP_B_INIT: begin
                    r_head <= '0;
                    r_tail <= TW'(1);
                end
                OP_B_POP: begin
                    r_head <= r_head + TW'(1);
                    r_s    <= '0;
                end
                OP_B_PGET: r_p <= r_queue_rd;
                OP_B_CSET: begin
                    r_c <= r_child_rd;
                    r_q <= r_fail_rd;
                    r_f <= '0;
                end
                OP_B_NEXT: r_s <= r_s + SW'(1);
                OP_B_QCHK: begin
                    if (r_child_rd != '0 || r_q == '0) begin
                        r_f <= r_child_rd;
                    end else begin
                        r_q <= r_fail_rd;
                    end
                end
                OP_B_HWR: begin
                    if (r_tail < TW'(MAX_NODES)) r_tail <= r_tail + TW'(1);
                    r_s <= r_s + SW'(1);
                end
                OP_C_INIT: begin
                    r_node_total <= TW'(1);
                    r_ins_pos    <= '0;
                    r_drop       <= 1'b0;
                    r_scan_pos   <= '0;
                    r_run        <= '0;
                    r_sweep      <= '0;
                end
                OP_SWEEP: r_sweep <= r_sweep + CAW'(1);
                OP_REPORT: begin
                    r_result.status     <= r_stat;
                    r_result.hits_here  <= r_hit;
                    r_result.hit_total  <= 16'(r_run);
                    r_result.nodes_used <= 11'(r_node_total);
                    if (r_item.action == ACT_SCAN && r_item.last) begin
                        r_run      <= '0;
                        r_scan_pos <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.action     = r_item.action;
        o_stat.last       = r_item.last;
        o_stat.child_nz   = (r_child_rd != '0) && (r_sym_ok || r_item.action == ACT_BUILD);
        o_stat.q_zero     = (r_q == '0);
        o_stat.p_zero     = (r_p == '0);
        o_stat.s_last     = (r_s == SW'(ALPHABET - 1));
        o_stat.more       = (r_head < r_tail);
        o_stat.sweep_last = (r_sweep == CAW'(CD - 1));
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: bench/aho_corasick_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aho_corasick_matcher_tb
// Self-checking bench for the letter matcher: a directed table of words
// followed by random insert/build/scan/clear phases; each result is checked
// against an in-bench automaton predictor or a fixed expected row value.
// ----------------------------------------------------------------------------
module aho_corasick_matcher_tb;
    import acm_pkg::*;

    localparam int NODES = 1024;
    localparam int ALPHA = 26;
    localparam int SAT_MAX = 65535;
    localparam int IDLE_LIMIT = 400000;
    localparam int RANDOM_WORDS = 530;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_done;
    t_result o_result;

    aho_corasick_matcher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_done  (o_done),
        .o_result(o_result)
    );

    // automaton predictor state
    logic [9:0]  trie_child [0:NODES*ALPHA-1];
    logic        trie_end   [0:NODES-1];
    logic [9:0]  fail_link  [0:NODES-1];
    logic [7:0]  node_score [0:NODES-1];
    int unsigned bfs_q      [0:NODES-1];
    int unsigned n_nodes, ins_pos, scan_pos, run_hits;
    bit          ins_drop;

    t_result     result_q [$];
    int          errors = 0;
    int          n_sent = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 0;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result res;
    } t_row;

    function automatic int unsigned child_get(int unsigned node, int unsigned sym);
        if (node >= NODES || sym >= ALPHA) return 0;
        return trie_child[node*ALPHA + sym];
    endfunction

    function automatic void trie_wipe();
        foreach (trie_child[k]) trie_child[k] = '0;
        for (int k = 0; k < NODES; k++) begin
            trie_end[k] = 0;
            fail_link[k] = '0;
            node_score[k] = '0;
        end
        n_nodes = 1;
        ins_pos = 0;
        ins_drop = 0;
        scan_pos = 0;
        run_hits = 0;
    endfunction

    function automatic void trie_insert(int unsigned sym, bit fin);
        int unsigned nxt;
        nxt = 0;
        if (!ins_drop) begin
            if (sym < ALPHA) begin
                nxt = child_get(ins_pos, sym);
                if (nxt == 0 && n_nodes < NODES) begin
                    nxt = n_nodes;
                    n_nodes++;
                    trie_child[ins_pos*ALPHA + sym] = nxt[9:0];
                end
            end
            if (nxt == 0) ins_drop = 1;
            else ins_pos = nxt;
        end
        if (fin) begin
            if (!ins_drop) trie_end[ins_pos] = 1;
            ins_pos = 0;
        end
    endfunction

    function automatic void links_build();
        int unsigned head, tail, p, c, f, q, h, g;
        head = 0;
        tail = 0;
        fail_link[0] = '0;
        node_score[0] = {7'd0, trie_end[0]};
        bfs_q[tail++] = 0;
        while (head < tail) begin
            p = bfs_q[head++];
            for (int s = 0; s < ALPHA; s++) begin
                c = child_get(p, s);
                if (c != 0) begin
                    f = 0;
                    if (p != 0) begin
                        q = fail_link[p];
                        g = 0;
                        while (g < NODES && q != 0 && child_get(q, s) == 0) begin
                            q = fail_link[q];
                            g++;
                        end
                        f = child_get(q, s);
                    end
                    fail_link[c] = f[9:0];
                    h = trie_end[c] + node_score[f];
                    node_score[c] = (h > 255) ? 8'd255 : h[7:0];
                    if (tail < NODES) bfs_q[tail++] = c;
                end
            end
        end
    endfunction

    function automatic int unsigned text_step(int unsigned sym);
        int unsigned p, g, hits, sum;
        p = scan_pos;
        g = 0;
        while (g < NODES && p != 0 && child_get(p, sym) == 0) begin
            p = fail_link[p];
            g++;
        end
        p = child_get(p, sym);
        hits = node_score[p];
        sum = run_hits + hits;
        run_hits = (sum > SAT_MAX) ? SAT_MAX : sum;
        scan_pos = p;
        return hits;
    endfunction

    function automatic t_result predict_word(t_item it);
        t_result r;
        r = '0;
        case (it.action)
            ACT_INSERT: begin
                trie_insert(it.letter, it.last);
                r.status = ins_drop;
                if (it.last) ins_drop = 0;
            end
            ACT_BUILD: links_build();
            ACT_SCAN:  r.hits_here = text_step(it.letter);
            default:   trie_wipe();
        endcase
        r.hit_total = run_hits[15:0];
        r.nodes_used = n_nodes[10:0];
        if (it.action == ACT_SCAN && it.last) begin
            scan_pos = 0;
            run_hits = 0;
        end
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_word(t_item it, bit typed = 0, t_result typed_res = '0);
        int gap;
        t_result r;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        r = predict_word(it);
        result_q.push_back(typed ? typed_res : r);
        n_sent++;
    endtask

    function automatic t_item mk(logic [1:0] act, int unsigned sym, bit fin);
        t_item it;
        it.action = act;
        it.letter = sym[4:0];
        it.last = fin;
        return it;
    endfunction

    function automatic int unsigned pick_letter(int unsigned span);
        if ($urandom_range(0, 24) == 0) return $urandom_range(ALPHA, 31);
        return $urandom_range(0, span - 1);
    endfunction

    task automatic random_phase();
        int unsigned span, len;
        span = ($urandom_range(0, 3) == 0) ? ALPHA : $urandom_range(1, 4);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(1, 8)) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
                send_word(mk(ACT_INSERT, pick_letter(span),
                             k == len - 1 || $urandom_range(0, 19) == 0));
        end
        if ($urandom_range(0, 5) != 0) send_word(mk(ACT_BUILD, $urandom_range(0, 31),
                                                      $urandom_range(0, 1)));
        repeat ($urandom_range(1, 5)) begin
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++)
                send_word(mk(ACT_SCAN, pick_letter(span), k == len - 1));
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // check results
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                errors++;
            end else begin
                want = result_q.pop_front();
                check_field("status", want.status, o_result.status);
                check_field("hits_here", want.hits_here, o_result.hits_here);
                check_field("hit_total", want.hit_total, o_result.hit_total);
                check_field("nodes_used", want.nodes_used, o_result.nodes_used);
            end
        end
    end

    always @(negedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_row dir_rows [$];
        t_result r0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        trie_wipe();
        r0 = '0;
        r0.nodes_used = 11'd1;
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 0, 0), 1'b1, r0});
        r0.status = 1'b1;
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 31, 1), 1'b1, r0});
        r0.status = 1'b0;
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 7, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 4, 1), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 18, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 7, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 4, 1), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 7, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 8, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 18, 1), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 7, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 4, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 17, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 18, 1), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 7, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_INSERT, 4, 1), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_BUILD, 31, 1), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 20, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 18, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 7, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 4, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 17, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 18, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 31, 0), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_SCAN, 25, 1), 1'b0, '0});
        dir_rows.push_back(t_row'{mk(ACT_CLEAR, 0, 0), 1'b1, r0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_word(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);

        while (n_sent < RANDOM_WORDS) begin
            random_phase();
            if ($urandom_range(0, 24) == 0) send_word(mk(ACT_CLEAR, 31, 1));
        end

        start <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
